### rtl/sctv_pkg.sv
// Package: constants, types and helper functions of the sync check table verifier.
package sctv_pkg;

	localparam int NUM_CLIENTS = 16;
	localparam int TABLE_DEPTH = 8;

	localparam int ENT_N  = NUM_CLIENTS * TABLE_DEPTH;
	localparam int ENT_AW = (ENT_N > 1) ? $clog2(ENT_N) : 1;
	localparam int CL_W   = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int DCNT_W = $clog2(TABLE_DEPTH + 1);

	localparam int TICK_W  = 32;
	localparam int LEVEL_W = 16;
	localparam int CRC_W   = 32;
	localparam int SEQ_W   = 32;
	localparam int BAD_W   = 8;
	localparam int ENT_W   = TICK_W + LEVEL_W + CRC_W;
	localparam int CLI_W   = BAD_W + TICK_W;

	localparam logic [1:0] REG_DEPTH      = 2'd0;
	localparam logic [1:0] REG_KICK_LIMIT = 2'd1;
	localparam logic [1:0] REG_PAUSE      = 2'd2;
	localparam logic [1:0] REG_PER_CLIENT = 2'd3;

	localparam logic MODE_STORE  = 1'b0;
	localparam logic MODE_VERIFY = 1'b1;

	typedef enum logic [2:0] {
		VERDICT_OK     = 3'd0,
		VERDICT_BAD    = 3'd1,
		VERDICT_LEVEL  = 3'd2,
		VERDICT_LATE   = 3'd3,
		VERDICT_EARLY  = 3'd4,
		VERDICT_STORED = 3'd5
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE
	} state_t;

	typedef struct packed {
		logic [DCNT_W-1:0] depth;
		logic [7:0]        kick_limit;
		logic              pause_on_bad;
		logic              per_client;
	} cfg_t;

	typedef struct packed {
		logic              re;
		logic [ENT_AW-1:0] raddr;
		logic              we;
		logic [ENT_AW-1:0] waddr;
		logic [ENT_W-1:0]  wdata;
	} ent_req_t;

	typedef struct packed {
		logic              we;
		logic [CL_W-1:0]   addr;
		logic [BAD_W-1:0]  bad;
		logic [TICK_W-1:0] last;
	} cli_wr_t;

	typedef struct packed {
		verdict_t          verdict;
		logic              kick;
		logic              pause;
		logic [BAD_W-1:0]  bad_count;
		logic              flush_request;
		logic [SEQ_W-1:0]  flush_sequence;
		logic [TICK_W-1:0] last_sync_tick;
	} result_t;

	function automatic logic [DCNT_W-1:0] depth_clamp(input logic [3:0] d);
		logic [DCNT_W-1:0] r;
		if (d == 4'd0) begin
			r = DCNT_W'(1);
		end else if (32'(d) > TABLE_DEPTH) begin
			r = DCNT_W'(TABLE_DEPTH);
		end else begin
			r = DCNT_W'(d);
		end
		return r;
	endfunction

	function automatic logic [CL_W-1:0] client_wrap(input logic [3:0] c);
		logic [CL_W-1:0] r;
		r = '0;
		for (int k = 0; k < 16; k++) begin
			if (c == 4'(k)) begin
				r = CL_W'(k % NUM_CLIENTS);
			end
		end
		return r;
	endfunction

	function automatic logic [ENT_AW-1:0] ent_addr(input logic [CL_W-1:0] tbl,
			input logic [IDX_W-1:0] idx);
		return ENT_AW'(tbl * TABLE_DEPTH) + ENT_AW'(idx);
	endfunction

endpackage

### rtl/sctv_ram.sv
// Generic simple dual-port RAM with registered read.
module sctv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/sctv_ctrl.sv
// Sequencer: table scan, verdict resolution and write-back requests.
module sctv_ctrl
	import sctv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_mode,
	input  logic [3:0]          in_client,
	input  logic [TICK_W-1:0]   in_tick,
	input  logic [LEVEL_W-1:0]  in_level,
	input  logic [CRC_W-1:0]    in_crc,
	input  logic [SEQ_W-1:0]    in_seq,
	output ent_req_t            ent_req,
	input  logic [ENT_W-1:0]    ent_rdata,
	output logic [CL_W-1:0]     cli_raddr,
	input  logic [CLI_W-1:0]    cli_rdata,
	output cli_wr_t             cli_wr,
	input  logic                out_free,
	output logic                res_load,
	output result_t             res
);

	state_t state_q, state_d;

	logic                mode_q;
	logic [CL_W-1:0]     cl_q;
	logic [CL_W-1:0]     tbl_q;
	logic [TICK_W-1:0]   tick_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [CRC_W-1:0]    crc_q;
	logic [SEQ_W-1:0]    seq_q;

	logic [DCNT_W-1:0]   rd_idx_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [TICK_W-1:0]   min_q;
	logic [IDX_W-1:0]    oldest_q;
	logic                found_q;
	logic                earlier_q;
	logic [LEVEL_W-1:0]  hit_level_q;
	logic [CRC_W-1:0]    hit_crc_q;

	logic                accept;
	logic                issue;
	logic                last_proc;
	logic [TICK_W-1:0]   e_tick;
	logic [LEVEL_W-1:0]  e_level;
	logic [CRC_W-1:0]    e_crc;
	logic [BAD_W-1:0]    bad_old, bad_new;
	logic [TICK_W-1:0]   ls_old, ls_new;

	assign accept    = in_valid && in_ready;
	assign issue     = (state_q == ST_SCAN) && (rd_idx_q < cfg.depth);
	assign last_proc = rd_vld_s1 && (DCNT_W'(idx_s1) == cfg.depth - DCNT_W'(1));
	assign {e_tick, e_level, e_crc} = ent_rdata;
	assign {bad_old, ls_old} = cli_rdata;
	assign cli_raddr = cl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		res_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_proc) begin
					state_d = ST_RESOLVE;
				end
			end
			ST_RESOLVE: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (accept) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + DCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= in_mode;
			cl_q      <= client_wrap(in_client);
			tbl_q     <= cfg.per_client ? client_wrap(in_client) : '0;
			tick_q    <= in_tick;
			level_q   <= in_level;
			crc_q     <= in_crc;
			seq_q     <= in_seq;
			found_q   <= 1'b0;
			earlier_q <= 1'b0;
			oldest_q  <= '0;
		end
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (rd_vld_s1) begin
			if (idx_s1 == '0 || e_tick < min_q) begin
				min_q    <= e_tick;
				oldest_q <= idx_s1;
			end
			if (!found_q) begin
				if (e_tick == tick_q) begin
					found_q     <= 1'b1;
					hit_level_q <= e_level;
					hit_crc_q   <= e_crc;
				end else if (e_tick < tick_q) begin
					earlier_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		res.verdict        = VERDICT_STORED;
		res.kick           = 1'b0;
		res.pause          = 1'b0;
		res.flush_request  = 1'b0;
		res.flush_sequence = '0;
		bad_new            = bad_old;
		ls_new             = ls_old;
		if (mode_q == MODE_VERIFY) begin
			if (found_q) begin
				res.flush_request  = 1'b1;
				res.flush_sequence = seq_q;
				if (hit_level_q != level_q) begin
					res.verdict = VERDICT_LEVEL;
					res.kick    = 1'b1;
				end else if (hit_crc_q != crc_q) begin
					res.verdict = VERDICT_BAD;
					bad_new = (bad_old == '1) ? bad_old : bad_old + BAD_W'(1);
					if (cfg.kick_limit != '0) begin
						res.kick = (bad_new >= cfg.kick_limit);
					end else begin
						res.pause = cfg.pause_on_bad;
					end
				end else begin
					res.verdict = VERDICT_OK;
					bad_new     = '0;
				end
				if (ls_old < tick_q) begin
					ls_new = tick_q;
				end
			end else if (!earlier_q) begin
				res.verdict = VERDICT_LATE;
			end else begin
				res.verdict = VERDICT_EARLY;
				if (ls_old < tick_q) begin
					ls_new = tick_q;
				end
			end
		end
		res.bad_count      = bad_new;
		res.last_sync_tick = ls_new;
	end

	always_comb begin
		ent_req.re    = issue;
		ent_req.raddr = ent_addr(tbl_q, rd_idx_q[IDX_W-1:0]);
		ent_req.we    = res_load && (mode_q == MODE_STORE);
		ent_req.waddr = ent_addr(tbl_q, oldest_q);
		ent_req.wdata = {tick_q, level_q, crc_q};
		cli_wr.we     = res_load && (mode_q == MODE_VERIFY);
		cli_wr.addr   = cl_q;
		cli_wr.bad    = bad_new;
		cli_wr.last   = ls_new;
	end

	a_no_read_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ent_req.re)
		else $error("table read issued while idle");

	a_scan_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_idx_q <= cfg.depth))
		else $error("scan index past depth in use");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN) && !rd_vld_s1)
		else $error("accepted item did not start a scan");

	a_writes_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ent_req.we && cli_wr.we) && !(ent_req.we && ent_req.re))
		else $error("conflicting memory accesses");

endmodule

### rtl/sync_check_table_verifier.sv
// Top level of the sync check table verifier: ports, registers, memories, result register.
//
// Usage:
//   s_* carries one record per transfer: s_tuser is the mode (0 store, 1 verify),
//   s_tdata the client, tick, level, CRC and stream sequence. Every record gives
//   exactly one result on m_*, in order.
//   cfg_* writes the registers (0 depth in use, 1 kick limit, 2 pause on bad CRC,
//   3 per-client tables); cfg_ready is always high. Writing the depth empties every
//   table. Write registers only while no record is in flight.
//   Scan: with D the depth in use after clamping to 1..8, each record reads the D
//   entries of its table in turn, and the next record is taken only after the
//   result is loaded into the output register; the table memory delivers one
//   entry per cycle through its single read port.
//   The result sits in an output register; the next record is taken while it waits.
//   When m_tready stays low a second finished result waits in the sequencer and no
//   further record is taken.
//   Reset clears all tables, bad-sync counters and last-sync ticks at once (valid
//   bits in flops) and restores register defaults: depth 8, kick limit 0, no pause,
//   per-client tables.
module sync_check_table_verifier
	import sctv_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [119:0] s_tdata,   // client[3:0], tick[35:4], level[51:36], crc[83:52], sequence_req[115:84]
	input  logic         s_tuser,   // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,   // verdict[2:0], kick[3], pause[4], bad_count[12:5], flush_request[13],
	                                // flush_sequence[45:14], last_sync_tick[77:46]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data
);

	logic [3:0]       depth_raw_q;
	logic [7:0]       kick_limit_q;
	logic             pause_q;
	logic             per_client_q;
	cfg_t             cfg;

	ent_req_t         ent_req;
	cli_wr_t          cli_wr;
	logic [CL_W-1:0]  cli_raddr;
	logic [ENT_W-1:0] ent_ram_rdata, ent_rdata;
	logic [CLI_W-1:0] cli_ram_rdata, cli_rdata;
	logic [ENT_N-1:0]       ent_valid_q;
	logic [NUM_CLIENTS-1:0] cli_valid_q;
	logic             ent_vld_s1;
	logic             cli_vld_s1;
	logic             cfg_wr;
	logic             depth_wr;

	logic             res_load;
	result_t          res;
	result_t          out_q;
	logic             m_valid_q;
	logic             out_free;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign depth_wr  = cfg_wr && (cfg_index == REG_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_raw_q  <= 4'd8;
			kick_limit_q <= '0;
			pause_q      <= 1'b0;
			per_client_q <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_DEPTH:      depth_raw_q  <= cfg_data[3:0];
				REG_KICK_LIMIT: kick_limit_q <= cfg_data;
				REG_PAUSE:      pause_q      <= cfg_data[0];
				REG_PER_CLIENT: per_client_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.depth        = depth_clamp(depth_raw_q);
		cfg.kick_limit   = kick_limit_q;
		cfg.pause_on_bad = pause_q;
		cfg.per_client   = per_client_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			cli_valid_q <= '0;
		end else begin
			if (depth_wr) begin
				ent_valid_q <= '0;
			end else if (ent_req.we) begin
				ent_valid_q[ent_req.waddr] <= 1'b1;
			end
			if (cli_wr.we) begin
				cli_valid_q[cli_wr.addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ent_req.re) begin
			ent_vld_s1 <= ent_valid_q[ent_req.raddr];
		end
		cli_vld_s1 <= cli_valid_q[cli_raddr];
	end

	assign ent_rdata = ent_vld_s1 ? ent_ram_rdata : '0;
	assign cli_rdata = cli_vld_s1 ? cli_ram_rdata : '0;

	sctv_ram #(.WIDTH(ENT_W), .DEPTH(ENT_N)) u_ent_ram (
		.clk   (clk),
		.we    (ent_req.we),
		.waddr (ent_req.waddr),
		.wdata (ent_req.wdata),
		.re    (ent_req.re),
		.raddr (ent_req.raddr),
		.rdata (ent_ram_rdata)
	);

	sctv_ram #(.WIDTH(CLI_W), .DEPTH(NUM_CLIENTS)) u_cli_ram (
		.clk   (clk),
		.we    (cli_wr.we),
		.waddr (cli_wr.addr),
		.wdata ({cli_wr.bad, cli_wr.last}),
		.re    (1'b1),
		.raddr (cli_raddr),
		.rdata (cli_ram_rdata)
	);

	sctv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_client (s_tdata[3:0]),
		.in_tick   (s_tdata[35:4]),
		.in_level  (s_tdata[51:36]),
		.in_crc    (s_tdata[83:52]),
		.in_seq    (s_tdata[115:84]),
		.ent_req   (ent_req),
		.ent_rdata (ent_rdata),
		.cli_raddr (cli_raddr),
		.cli_rdata (cli_rdata),
		.cli_wr    (cli_wr),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res)
	);

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, out_q.last_sync_tick, out_q.flush_sequence, out_q.flush_request,
		out_q.bad_count, out_q.pause, out_q.kick, out_q.verdict};

endmodule
